FILE: hw/rtl/ccat_pkg.sv
// shared types, codes and constants of the calendar clock with alarm table
package ccat_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int NREP_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_FIRED   = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;
  localparam logic [1:0] STAT_ACK     = 2'd3;

  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_REFRACT  = 1'b1;

  localparam logic [11:0] MIN_YEAR_RESET = 12'd2020;
  localparam logic [5:0]  REFRACT_RESET  = 6'd60;
  localparam logic [5:0]  STEP_LIMIT     = 6'd60;

  localparam logic [11:0] YEAR_RESET    = 12'd2000;
  localparam logic [3:0]  MONTH_RESET   = 4'd1;
  localparam logic [4:0]  DAY_RESET     = 5'd1;
  localparam logic [2:0]  WEEKDAY_RESET = 3'd6;

  localparam logic [11:0] SEC_MAX   = 12'd59;
  localparam logic [11:0] MIN_MAX   = 12'd59;
  localparam logic [11:0] HOUR_MAX  = 12'd23;
  localparam logic [11:0] WDAY_MAX  = 12'd7;
  localparam logic [11:0] MONTH_MAX = 12'd12;
  localparam logic [11:0] YEAR_MAX  = 12'd4095;
  localparam logic [12:0] SEC_WRAP  = 13'd60;

  // year / 100 as (year * 5243) >> 19, exact below 4096
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int          CENT_SHIFT = 19;
  localparam logic [11:0] CENT       = 12'd100;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } time_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  week;
    logic        enable;
  } alarm_t;

  typedef struct packed {
    alarm_t     alarm;
    logic [5:0] count;
  } entry_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic       last;
  } res_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      len = 5'd31;
      if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
        len = 5'd30;
      end else if (month == 4'd2) begin
        len = leap ? 5'd29 : 5'd28;
      end
      return len;
    end
  endfunction

endpackage

FILE: hw/rtl/ccat_ram.sv
// generic single write port, single read port ram with registered read
module ccat_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/ccat_cal.sv
// calendar time registers and the field by field carry sequencer
module ccat_cal (
  input  logic              clk,
  input  logic              rst,
  input  logic              set_en,
  input  ccat_pkg::time_t   set_time,
  input  logic              adv_start,
  input  logic [5:0]        step,
  output ccat_pkg::time_t   now,
  output logic              done
);

  typedef enum logic [3:0] {
    C_IDLE, C_MIN, C_HOUR, C_WDAY, C_LEAP, C_LEAP2, C_DAY, C_MON, C_YEAR
  } cstate_t;

  cstate_t     state;
  logic [5:0]  cent;
  logic        leap;

  logic [11:0] opnd;
  logic [11:0] lim;
  logic [11:0] wrap;
  logic [5:0]  addend;
  logic [12:0] sum;
  logic        carry;
  logic [12:0] res;
  logic [24:0] prod;
  logic [11:0] hund;
  logic [11:0] rem;

  // shared increment and limit compare
  always_comb begin
    opnd   = 12'(now.second);
    lim    = ccat_pkg::SEC_MAX;
    wrap   = '0;
    addend = 6'd1;
    unique case (state)
      C_IDLE: begin
        addend = step;
      end
      C_MIN: begin
        opnd = 12'(now.minute);
        lim  = ccat_pkg::MIN_MAX;
      end
      C_HOUR: begin
        opnd = 12'(now.hour);
        lim  = ccat_pkg::HOUR_MAX;
      end
      C_WDAY: begin
        opnd = 12'(now.weekday);
        lim  = ccat_pkg::WDAY_MAX;
        wrap = 12'd1;
      end
      C_DAY: begin
        opnd = 12'(now.day);
        lim  = 12'(ccat_pkg::month_len(now.month, leap));
        wrap = 12'd1;
      end
      C_MON: begin
        opnd = 12'(now.month);
        lim  = ccat_pkg::MONTH_MAX;
        wrap = 12'd1;
      end
      C_YEAR: begin
        opnd = now.year;
        lim  = ccat_pkg::YEAR_MAX;
      end
      default: begin
        opnd = 12'(now.second);
      end
    endcase
    sum   = 13'(opnd) + 13'(addend);
    carry = sum > 13'(lim);
    if (!carry) begin
      res = sum;
    end else if (state == C_IDLE) begin
      res = sum - ccat_pkg::SEC_WRAP;
    end else begin
      res = 13'(wrap);
    end
  end

  assign prod = 25'(now.year) * 25'(ccat_pkg::CENT_RECIP);
  assign hund = 12'(cent) * ccat_pkg::CENT;
  assign rem  = now.year - hund;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= C_IDLE;
      done        <= 1'b0;
      leap        <= 1'b0;
      cent        <= '0;
      now.year    <= ccat_pkg::YEAR_RESET;
      now.month   <= ccat_pkg::MONTH_RESET;
      now.day     <= ccat_pkg::DAY_RESET;
      now.hour    <= '0;
      now.minute  <= '0;
      now.second  <= '0;
      now.weekday <= ccat_pkg::WEEKDAY_RESET;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (set_en) begin
            now <= set_time;
          end else if (adv_start) begin
            now.second <= res[5:0];
            if (carry) begin
              state <= C_MIN;
            end else begin
              done <= 1'b1;
            end
          end
        end
        C_MIN: begin
          now.minute <= res[5:0];
          if (carry) begin
            state <= C_HOUR;
          end else begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        C_HOUR: begin
          now.hour <= res[4:0];
          if (carry) begin
            state <= C_WDAY;
          end else begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        C_WDAY: begin
          now.weekday <= res[2:0];
          state       <= C_LEAP;
        end
        C_LEAP: begin
          cent  <= prod[ccat_pkg::CENT_SHIFT +: 6];
          state <= C_LEAP2;
        end
        C_LEAP2: begin
          leap  <= (now.year[1:0] == 2'd0 && rem != '0) || (rem == '0 && cent[1:0] == 2'd0);
          state <= C_DAY;
        end
        C_DAY: begin
          now.day <= res[4:0];
          if (carry) begin
            state <= C_MON;
          end else begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        C_MON: begin
          now.month <= res[3:0];
          if (carry) begin
            state <= C_YEAR;
          end else begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        C_YEAR: begin
          now.year <= res[11:0];
          done     <= 1'b1;
          state    <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/ccat_tbl.sv
// alarm slot table: slot writes, clear, and the one slot per cycle scan, which holds while a push is stalled
module ccat_tbl #(
  parameter int NUM_ALARMS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [3:0]        wr_index,
  input  ccat_pkg::alarm_t  wr_alarm,
  input  logic              clr,
  input  logic              scan_start,
  input  ccat_pkg::time_t   now,
  input  logic [5:0]        refract_limit,
  output logic              push_valid,
  output ccat_pkg::res_t    push_res,
  input  logic              push_ready
);

  localparam int AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int CW = $clog2(NUM_ALARMS + 1);
  localparam int EW = $bits(ccat_pkg::entry_t);

  typedef enum logic [1:0] {T_IDLE, T_EVAL, T_DONE} tstate_t;

  tstate_t                    state;
  logic [CW-1:0]              idx;
  logic                       pend_valid;
  logic [3:0]                 pend_slot;
  logic [ccat_pkg::NREP_W-1:0] nrep;
  logic [NUM_ALARMS-1:0]      valid;

  logic [EW-1:0]              rd_data;
  ccat_pkg::entry_t           entry;
  ccat_pkg::alarm_t           a;
  logic [CW-1:0]              idx_nxt;
  logic [CW+3:0]              idx_ext;
  logic [AW+3:0]              wr_ext;
  logic [AW-1:0]              wr_addr;
  logic                       wr_ok;
  logic                       last_idx;
  logic                       day_ok;
  logic [6:0]                 cnt_inc;
  logic [5:0]                 cnt_mid;
  logic [5:0]                 cnt_new;
  logic                       fire;
  logic                       fire_rep;
  logic                       need_push;
  logic                       stall;
  logic                       ram_wr_en;
  logic [AW-1:0]              ram_wr_addr;
  logic [EW-1:0]              ram_wr_data;
  logic                       ram_rd_en;
  logic [AW-1:0]              ram_rd_addr;

  assign wr_ext   = (AW + 4)'(wr_index);
  assign wr_addr  = wr_ext[AW-1:0];
  assign wr_ok    = 7'(wr_index) < 7'(NUM_ALARMS);
  assign idx_nxt  = idx + CW'(1);
  assign idx_ext  = (CW + 4)'(idx);
  assign last_idx = idx == CW'(NUM_ALARMS - 1);

  assign entry = valid[idx[AW-1:0]] ? ccat_pkg::entry_t'(rd_data) : '0;
  assign a     = entry.alarm;

  always_comb begin
    if (a.week != '0) begin
      day_ok = (now.weekday != '0) && a.week[3'(now.weekday - 3'd1)];
    end else begin
      day_ok = (a.year != '0) && a.year == now.year && a.month == now.month &&
               a.day == now.day;
    end
    cnt_inc = 7'(entry.count) + 7'd1;
    if (entry.count == '0 || cnt_inc > 7'(refract_limit)) begin
      cnt_mid = '0;
    end else begin
      cnt_mid = cnt_inc[5:0];
    end
    fire = a.enable && day_ok && a.hour == now.hour && a.minute == now.minute &&
           a.second == now.second && cnt_mid == '0;
    cnt_new   = fire ? 6'd1 : cnt_mid;
    fire_rep  = fire && (nrep < ccat_pkg::NREP_W'(ccat_pkg::MAX_RESULTS));
    need_push = (state == T_EVAL) && fire_rep && pend_valid;
    stall     = need_push && !push_ready;
  end

  always_comb begin
    push_valid = need_push || (state == T_DONE);
    if (state == T_DONE) begin
      push_res.status = pend_valid ? ccat_pkg::STAT_FIRED : ccat_pkg::STAT_NONE;
      push_res.slot   = pend_valid ? pend_slot : 4'd0;
      push_res.last   = 1'b1;
    end else begin
      push_res.status = ccat_pkg::STAT_FIRED;
      push_res.slot   = pend_slot;
      push_res.last   = 1'b0;
    end
  end

  always_comb begin
    if (state == T_EVAL) begin
      ram_wr_en   = a.enable;
      ram_wr_addr = idx[AW-1:0];
      ram_wr_data = {a, cnt_new};
      ram_rd_en   = !stall && !last_idx;
      ram_rd_addr = idx_nxt[AW-1:0];
    end else begin
      ram_wr_en   = (state == T_IDLE) && wr_en && wr_ok;
      ram_wr_addr = wr_addr;
      ram_wr_data = {wr_alarm, 6'd0};
      ram_rd_en   = (state == T_IDLE) && scan_start;
      ram_rd_addr = '0;
    end
  end

  ccat_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_ALARMS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
      pend_slot  <= '0;
      nrep       <= '0;
      valid      <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (clr) begin
            valid <= '0;
          end else if (wr_en && wr_ok) begin
            valid[wr_addr] <= 1'b1;
          end
          if (scan_start) begin
            idx        <= '0;
            pend_valid <= 1'b0;
            nrep       <= '0;
            state      <= T_EVAL;
          end
        end
        T_EVAL: begin
          if (!stall) begin
            if (fire_rep) begin
              pend_valid <= 1'b1;
              pend_slot  <= idx_ext[3:0];
              nrep       <= nrep + ccat_pkg::NREP_W'(1);
            end
            if (last_idx) begin
              state <= T_DONE;
            end else begin
              idx <= idx_nxt;
            end
          end
        end
        T_DONE: begin
          if (push_ready) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/calendar_clock_with_alarm_table_core.sv
// top level: request decode, config registers and result output register
// a tick runs the carry sequencer, one year check and the slot scan, one slot a cycle while
// the output is not stalled; the scan is suppressed below the minimum year, and the next
// request is taken only once the last result is loaded; other requests give a single result
// reset loads 2000-01-01 00:00:00 weekday 6 and the config defaults, and empties the
// slot table at once through per-slot valid bits
module calendar_clock_with_alarm_table_core #(
  parameter int NUM_ALARMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // step_seconds, slot_index, year, month, day, hour, minute, sec, week_value, enable
  input  logic [55:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // alarm_slot, zero fill
  output logic [7:0]  m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_ADV, S_CHK, S_SCAN, S_RESP} state_t;

  state_t            state;
  logic [11:0]       min_year;
  logic [5:0]        refract;
  logic [1:0]        resp_status;
  logic [3:0]        m_slot;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [1:0]        req_type;
  logic [5:0]        step_seconds;
  logic [3:0]        slot_index;
  ccat_pkg::time_t   set_time;
  ccat_pkg::alarm_t  wr_alarm;
  ccat_pkg::time_t   now;
  logic              cal_done;
  logic              push_valid;
  ccat_pkg::res_t    push_res;
  logic              year_ok;

  assign req_type     = s_axis_tuser;
  assign step_seconds = s_axis_tdata[5:0];
  assign slot_index   = s_axis_tdata[9:6];

  assign set_time.year    = s_axis_tdata[21:10];
  assign set_time.month   = s_axis_tdata[25:22];
  assign set_time.day     = s_axis_tdata[30:26];
  assign set_time.hour    = s_axis_tdata[35:31];
  assign set_time.minute  = s_axis_tdata[41:36];
  assign set_time.second  = s_axis_tdata[47:42];
  assign set_time.weekday = s_axis_tdata[50:48];

  assign wr_alarm.year   = s_axis_tdata[21:10];
  assign wr_alarm.month  = s_axis_tdata[25:22];
  assign wr_alarm.day    = s_axis_tdata[30:26];
  assign wr_alarm.hour   = s_axis_tdata[35:31];
  assign wr_alarm.minute = s_axis_tdata[41:36];
  assign wr_alarm.second = s_axis_tdata[47:42];
  assign wr_alarm.week   = s_axis_tdata[54:48];
  assign wr_alarm.enable = s_axis_tdata[55];

  assign s_axis_tready = state == S_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = out_free && ((state == S_SCAN && push_valid) || state == S_RESP);
  assign year_ok       = now.year >= min_year;
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {4'd0, m_slot};

  ccat_cal u_cal (
    .clk       (clk),
    .rst       (rst),
    .set_en    (accept && req_type == ccat_pkg::REQ_SET),
    .set_time  (set_time),
    .adv_start (accept && req_type == ccat_pkg::REQ_TICK &&
                step_seconds < ccat_pkg::STEP_LIMIT),
    .step      (step_seconds),
    .now       (now),
    .done      (cal_done)
  );

  ccat_tbl #(
    .NUM_ALARMS (NUM_ALARMS)
  ) u_tbl (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (accept && req_type == ccat_pkg::REQ_WRITE),
    .wr_index      (slot_index),
    .wr_alarm      (wr_alarm),
    .clr           (accept && req_type == ccat_pkg::REQ_CLEAR),
    .scan_start    (state == S_CHK && year_ok),
    .now           (now),
    .refract_limit (refract),
    .push_valid    (push_valid),
    .push_res      (push_res),
    .push_ready    (state == S_SCAN && out_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= ccat_pkg::MIN_YEAR_RESET;
      refract  <= ccat_pkg::REFRACT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccat_pkg::CFG_MIN_YEAR: min_year <= cfg_data;
        ccat_pkg::CFG_REFRACT:  refract  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      resp_status   <= ccat_pkg::STAT_NONE;
      m_axis_tvalid <= 1'b0;
      m_axis_tuser  <= '0;
      m_axis_tlast  <= 1'b0;
      m_slot        <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_type != ccat_pkg::REQ_TICK) begin
              resp_status <= ccat_pkg::STAT_ACK;
              state       <= S_RESP;
            end else if (step_seconds >= ccat_pkg::STEP_LIMIT) begin
              resp_status <= ccat_pkg::STAT_IGNORED;
              state       <= S_RESP;
            end else begin
              state <= S_ADV;
            end
          end
        end
        S_ADV: begin
          if (cal_done) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (year_ok) begin
            state <= S_SCAN;
          end else begin
            resp_status <= ccat_pkg::STAT_NONE;
            state       <= S_RESP;
          end
        end
        S_SCAN: begin
          if (push_valid && out_free) begin
            m_axis_tuser  <= push_res.status;
            m_slot        <= push_res.slot;
            m_axis_tlast  <= push_res.last;
            if (push_res.last) begin
              state <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_axis_tuser  <= resp_status;
            m_slot        <= '0;
            m_axis_tlast  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
